// ----- rtl/core/fsta_pkg.sv -----
// ----------------------------------------------------------------------------
// fsta_pkg: shared types and constants
// Widths, arithmetic constants, register indexes, sequencer states and the
// lane control word of the flex sensor to servo angle block.
// ----------------------------------------------------------------------------
package fsta_pkg;

  // channel count and field widths
  localparam int NUM_CH = 4;
  localparam int SMP_W  = 10;
  localparam int ANG_W  = 8;
  localparam int SUM_W  = 16;
  localparam int CFG_IDX_W = 3;

  // shared divider: dividend covers offset * 180 (max 184140), divisor 10 bits
  localparam int DIV_W  = 18;
  localparam int DVR_W  = 10;
  localparam int STEP_W = $clog2(DIV_W);

  // arithmetic constants
  localparam int SAMPLES_DEF = 30;
  localparam logic [ANG_W-1:0] ANGLE_FULL = 8'd180;
  localparam logic [DVR_W-1:0] ROUND_DIV  = 10'd10;
  localparam logic [DIV_W-1:0] ROUND_BIAS = 18'd5;
  localparam logic [SMP_W-1:0] LOW_RST    = 10'd0;
  localparam logic [SMP_W-1:0] HIGH_RST   = 10'd1023;

  // reciprocal multiply for constant divisors; dividends stay below 2**RCP_W,
  // multiplier ceil(2**(RCP_W + clog2(d)) / d) gives the exact floor quotient
  localparam int RCP_W   = SUM_W + 1;
  localparam int RND_SH  = RCP_W + $clog2(int'(ROUND_DIV));
  localparam int RND_MUL = ((1 << RND_SH) + int'(ROUND_DIV) - 1) / int'(ROUND_DIV);
  localparam int PROD_W  = 2 * RCP_W + 6;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CH0_LOW  = 3'd0,
    REG_CH0_HIGH = 3'd1,
    REG_CH1_LOW  = 3'd2,
    REG_CH1_HIGH = 3'd3,
    REG_CH2_LOW  = 3'd4,
    REG_CH2_HIGH = 3'd5,
    REG_CH3_LOW  = 3'd6,
    REG_CH3_HIGH = 3'd7
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_ACC,
    ST_RND,
    ST_AVG,
    ST_MUL,
    ST_LD_ANG,
    ST_DIV_ANG,
    ST_FINISH,
    ST_OUT
  } state_t;

  // per-cycle lane operation
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACC,
    OP_ROUND,
    OP_AVG,
    OP_STEP,
    OP_MUL,
    OP_LD_ANGLE,
    OP_FINISH
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     push;
  } ctl_t;

endpackage

// ----- rtl/core/fsta_if.sv -----
// ----------------------------------------------------------------------------
// fsta_in_if / fsta_out_if: sample and angle channels
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface fsta_in_if;
  import fsta_pkg::*;

  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] chan0_sample;
  logic [SMP_W-1:0] chan1_sample;
  logic [SMP_W-1:0] chan2_sample;
  logic [SMP_W-1:0] chan3_sample;

  modport source (output valid, chan0_sample, chan1_sample, chan2_sample, chan3_sample,
                  input ready);
  modport sink   (input valid, chan0_sample, chan1_sample, chan2_sample, chan3_sample,
                  output ready);
endinterface

interface fsta_out_if;
  import fsta_pkg::*;

  logic             valid;
  logic             ready;
  logic [ANG_W-1:0] chan0_angle;
  logic [ANG_W-1:0] chan1_angle;
  logic [ANG_W-1:0] chan2_angle;
  logic [ANG_W-1:0] chan3_angle;
  logic             chan0_updated;
  logic             chan1_updated;
  logic             chan2_updated;
  logic             chan3_updated;

  modport source (output valid, chan0_angle, chan1_angle, chan2_angle, chan3_angle,
                  chan0_updated, chan1_updated, chan2_updated, chan3_updated,
                  input ready);
  modport sink   (input valid, chan0_angle, chan1_angle, chan2_angle, chan3_angle,
                  chan0_updated, chan1_updated, chan2_updated, chan3_updated,
                  output ready);
endinterface

// ----- rtl/core/fsta_lane.sv -----
// ----------------------------------------------------------------------------
// fsta_lane: one channel's accumulator, divider and angle mapper
// Sums samples over a window, rounds to tens and averages by reciprocal
// multiplication, then scales the angle by a restoring division by the span.
// ----------------------------------------------------------------------------
module fsta_lane #(
  parameter int SAMPLES = fsta_pkg::SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fsta_pkg::ctl_t             ctl,
  input  logic [fsta_pkg::SMP_W-1:0] sample,
  input  logic [fsta_pkg::SMP_W-1:0] lo,
  input  logic [fsta_pkg::SMP_W-1:0] hi,
  output logic [fsta_pkg::ANG_W-1:0] angle,
  output logic                       updated
);
  import fsta_pkg::*;

  // average: floor(10 * q / SAMPLES) as one multiply by a constant
  localparam int     AVG_SH    = RCP_W + $clog2(SAMPLES);
  localparam longint AVG_MUL   = ((longint'(1) << AVG_SH) + longint'(SAMPLES) - 1) /
                                 longint'(SAMPLES);
  localparam longint AVG_MUL10 = AVG_MUL * longint'(ROUND_DIV);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [DIV_W-1:0] quot_r, quot_nxt;
  logic [DVR_W-1:0] rem_r, rem_nxt;
  logic [DVR_W-1:0] dvs_r, dvs_nxt;
  logic [SMP_W-1:0] span_r, span_nxt;
  logic             in_win_r, in_win_nxt;
  logic [ANG_W-1:0] held_r, held_nxt;
  logic             upd_r, upd_nxt;

  logic [DVR_W:0]    trial;
  logic [DVR_W:0]    diff;
  logic              fits;
  logic [SMP_W-1:0]  offset;
  logic [DIV_W-1:0]  product;
  logic [DIV_W-1:0]  rnd_num;
  logic [PROD_W-1:0] rnd_prod;
  logic [PROD_W-1:0] avg_prod;

  // one restoring divide step: shift in the next dividend bit, try subtract
  assign trial = {rem_r, quot_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  // rounding to tens and block average
  assign rnd_num  = DIV_W'(sum_r) + ROUND_BIAS;
  assign rnd_prod = PROD_W'(rnd_num) * PROD_W'(RND_MUL);
  assign avg_prod = PROD_W'(quot_r) * PROD_W'(AVG_MUL10);

  // offset into the window and its scaled value
  assign offset  = quot_r[SMP_W-1:0] - lo;
  assign product = DIV_W'(offset) * DIV_W'(ANGLE_FULL);

  always_comb begin
    sum_nxt    = sum_r;
    quot_nxt   = quot_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    span_nxt   = span_r;
    in_win_nxt = in_win_r;
    held_nxt   = held_r;
    upd_nxt    = upd_r;
    unique case (ctl.op)
      OP_NONE: begin
      end
      OP_ACC: begin
        sum_nxt = sum_r + SUM_W'(sample);
      end
      OP_ROUND: begin
        // (sum + 5) / 10
        quot_nxt = rnd_prod[RND_SH +: DIV_W];
      end
      OP_AVG: begin
        // quotient times ten, over SAMPLES
        quot_nxt = DIV_W'(avg_prod >> AVG_SH);
      end
      OP_STEP: begin
        quot_nxt = {quot_r[DIV_W-2:0], fits};
        rem_nxt  = fits ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
      end
      OP_MUL: begin
        // quotient now holds the block average
        in_win_nxt = (quot_r > DIV_W'(lo)) && (quot_r <= DIV_W'(hi));
        span_nxt   = hi - lo;
        quot_nxt   = product;
      end
      OP_LD_ANGLE: begin
        rem_nxt = '0;
        dvs_nxt = span_r;
      end
      OP_FINISH: begin
        if (in_win_r) begin
          held_nxt = ANGLE_FULL - quot_r[ANG_W-1:0];
        end
        upd_nxt = in_win_r;
        sum_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      held_r <= ANGLE_FULL;
      upd_r  <= 1'b0;
    end else begin
      sum_r  <= sum_nxt;
      held_r <= held_nxt;
      upd_r  <= upd_nxt;
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    quot_r   <= quot_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    span_r   <= span_nxt;
    in_win_r <= in_win_nxt;
  end

  assign angle   = held_r;
  assign updated = upd_r;

endmodule

// ----- rtl/core/fsta_ctrl.sv -----
// ----------------------------------------------------------------------------
// fsta_ctrl: window counter and lane sequencer
// Counts accepted transactions; on the last one of a window it steps all
// lanes through the average and map sequence, then hands the result over.
// ----------------------------------------------------------------------------
module fsta_ctrl #(
  parameter int SAMPLES = fsta_pkg::SAMPLES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           can_load,
  output fsta_pkg::ctl_t ctl
);
  import fsta_pkg::*;

  localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               accept;
  logic               last_item;
  logic               last_step;
  logic               in_div;

  assign in_ready  = (state_r == ST_ACC);
  assign accept    = in_valid && in_ready;
  assign last_item = (cnt_r == CNT_W'(SAMPLES - 1));
  assign last_step = (step_r == STEP_W'(DIV_W - 1));
  assign in_div    = (state_r == ST_DIV_ANG);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACC:     if (accept && last_item) state_nxt = ST_RND;
      ST_RND:     state_nxt = ST_AVG;
      ST_AVG:     state_nxt = ST_MUL;
      ST_MUL:     state_nxt = ST_LD_ANG;
      ST_LD_ANG:  state_nxt = ST_DIV_ANG;
      ST_DIV_ANG: if (last_step) state_nxt = ST_FINISH;
      ST_FINISH:  state_nxt = ST_OUT;
      ST_OUT:     if (can_load) state_nxt = ST_ACC;
      default:    state_nxt = ST_ACC;
    endcase
  end

  // lane operation and result push
  always_comb begin
    ctl.op   = OP_NONE;
    ctl.push = 1'b0;
    unique case (state_r)
      ST_ACC:     ctl.op = accept ? OP_ACC : OP_NONE;
      ST_RND:     ctl.op = OP_ROUND;
      ST_AVG:     ctl.op = OP_AVG;
      ST_MUL:     ctl.op = OP_MUL;
      ST_LD_ANG:  ctl.op = OP_LD_ANGLE;
      ST_DIV_ANG: ctl.op = OP_STEP;
      ST_FINISH:  ctl.op = OP_FINISH;
      ST_OUT:     ctl.push = can_load;
      default:    ctl.op = OP_NONE;
    endcase
  end

  // window and divide step counters
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = last_item ? '0 : cnt_r + 1'b1;
    end
    step_nxt = in_div ? (last_step ? '0 : step_r + 1'b1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      cnt_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ----- rtl/core/fsta_merge.sv -----
// ----------------------------------------------------------------------------
// fsta_merge: result register
// Gathers the four lane angles and flags into one output transaction and
// holds it until the receiver takes it.
// ----------------------------------------------------------------------------
module fsta_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fsta_pkg::ctl_t             ctl,
  input  logic [fsta_pkg::ANG_W-1:0] angle   [fsta_pkg::NUM_CH],
  input  logic                       updated [fsta_pkg::NUM_CH],
  output logic                       can_load,
  fsta_out_if.source                 out_ch
);
  import fsta_pkg::*;

  logic             valid_r, valid_nxt;
  logic [ANG_W-1:0] angle_r [NUM_CH];
  logic             upd_r   [NUM_CH];

  // slot is free when empty or being drained this cycle
  assign can_load  = !valid_r || out_ch.ready;
  assign valid_nxt = ctl.push ? 1'b1 : (out_ch.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      angle_r <= angle;
      upd_r   <= updated;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.chan0_angle   = angle_r[0];
  assign out_ch.chan1_angle   = angle_r[1];
  assign out_ch.chan2_angle   = angle_r[2];
  assign out_ch.chan3_angle   = angle_r[3];
  assign out_ch.chan0_updated = upd_r[0];
  assign out_ch.chan1_updated = upd_r[1];
  assign out_ch.chan2_updated = upd_r[2];
  assign out_ch.chan3_updated = upd_r[3];

endmodule

// ----- rtl/core/flex_sensor_to_servo_angle_top.sv -----
// ----------------------------------------------------------------------------
// flex_sensor_to_servo_angle_top: flex sensor block averager and servo mapper
// Four sample lanes, a shared sequencer and a result register.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one set of four 10-bit samples per transaction. Every
//   SAMPLES-th transaction closes a window: each lane rounds its sum to tens,
//   averages it, and if low < avg <= high maps it to an angle in 0..180.
//   out_ch then carries four angles (new or held) and four updated flags.
//   Other transactions produce no output.
//   cfg_we/cfg_index/cfg_wdata write the eight window bounds (low, high per
//   channel); write them only while the block is idle.
// Sequence:
//   Transactions that do not close a window are accepted back to back. After
//   a closing one, no input is accepted while each lane rounds and averages
//   by reciprocal multiply, then runs a restoring division per lane for the
//   angle scale, with multiply, load and finish steps around it; the result
//   is then loaded into the output register as soon as that is free.
// Reset: sums and window count clear, angles return to 180, bounds to
//   0 and 1023, output valid drops.
// Stall: a result waits in the output register; the next window keeps
//   accumulating, and only the hand-over of its result waits on out_ch.ready.
// ----------------------------------------------------------------------------
module flex_sensor_to_servo_angle_top #(
  parameter int SAMPLES = fsta_pkg::SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fsta_in_if.sink                        in_ch,
  fsta_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [fsta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsta_pkg::SMP_W-1:0]     cfg_wdata
);
  import fsta_pkg::*;

  ctl_t             ctl;
  logic             can_load;
  logic             in_ready;
  logic [SMP_W-1:0] low_r  [NUM_CH];
  logic [SMP_W-1:0] high_r [NUM_CH];
  logic [SMP_W-1:0] sample [NUM_CH];
  logic [ANG_W-1:0] angle  [NUM_CH];
  logic             updated[NUM_CH];

  assign in_ch.ready = in_ready;
  assign sample[0]   = in_ch.chan0_sample;
  assign sample[1]   = in_ch.chan1_sample;
  assign sample[2]   = in_ch.chan2_sample;
  assign sample[3]   = in_ch.chan3_sample;

  // window bound registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        low_r[i]  <= LOW_RST;
        high_r[i] <= HIGH_RST;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CH0_LOW:  low_r[0]  <= cfg_wdata;
        REG_CH0_HIGH: high_r[0] <= cfg_wdata;
        REG_CH1_LOW:  low_r[1]  <= cfg_wdata;
        REG_CH1_HIGH: high_r[1] <= cfg_wdata;
        REG_CH2_LOW:  low_r[2]  <= cfg_wdata;
        REG_CH2_HIGH: high_r[2] <= cfg_wdata;
        REG_CH3_LOW:  low_r[3]  <= cfg_wdata;
        REG_CH3_HIGH: high_r[3] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  fsta_ctrl #(.SAMPLES(SAMPLES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .can_load (can_load),
    .ctl      (ctl)
  );

  // one lane per channel
  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    fsta_lane #(.SAMPLES(SAMPLES)) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .sample  (sample[g]),
      .lo      (low_r[g]),
      .hi      (high_r[g]),
      .angle   (angle[g]),
      .updated (updated[g])
    );
  end

  // result register
  fsta_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .angle    (angle),
    .updated  (updated),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

// ----- rtl/core/fsta_checker.sv -----
// ----------------------------------------------------------------------------
// fsta_checker: port-level checks of the flex sensor block
// Watches the channels of the top level; bound in below.
// ----------------------------------------------------------------------------
module fsta_checker (
  input logic         clk,
  input logic         rst_n,
  fsta_in_if.sink     in_ch,
  fsta_out_if.source  out_ch
);
  import fsta_pkg::*;

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("output transaction dropped while stalled");

  // no result left over after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  // angles stay in 0..180
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.chan0_angle <= ANGLE_FULL) &&
                     (out_ch.chan1_angle <= ANGLE_FULL) &&
                     (out_ch.chan2_angle <= ANGLE_FULL) &&
                     (out_ch.chan3_angle <= ANGLE_FULL))
    else $error("angle out of range");

  // a result never appears right after an input transaction
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !$rose(out_ch.valid))
    else $error("result issued too early");

endmodule

bind flex_sensor_to_servo_angle_top fsta_checker u_fsta_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: flex sensor to servo angle block testbench
// Drives four-channel sample sets into the block and rebuilds every window
// average and servo angle in a local predictor, then compares each angle
// transaction field by field. A table of directed windows comes first. It
// covers the reset bounds, the bound edges, empty and inverted windows and
// rounding. Random phases follow; each loads new bounds while the block is
// idle. Both channels idle at random, and the bound writes land mid-window.
// ----------------------------------------------------------------------------
module tb;
  import fsta_pkg::*;

  localparam int WIN          = SAMPLES_DEF;
  localparam int GUARD_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DIR_ROWS     = 8;
  localparam int SMP_MAX      = (1 << SMP_W) - 1;
  localparam int MAX_PRINTS   = 50;

  localparam cfg_reg_t LOW_REG [NUM_CH] = '{REG_CH0_LOW, REG_CH1_LOW,
                                            REG_CH2_LOW, REG_CH3_LOW};
  localparam cfg_reg_t HIGH_REG [NUM_CH] = '{REG_CH0_HIGH, REG_CH1_HIGH,
                                             REG_CH2_HIGH, REG_CH3_HIGH};

  typedef logic [NUM_CH-1:0][SMP_W-1:0] smp_set_t;

  typedef struct packed {
    logic [NUM_CH-1:0][ANG_W-1:0] angle;
    logic [NUM_CH-1:0]            upd;
  } angle_res_t;

  // one directed window: bounds, two alternating sample sets, typed result
  typedef struct {
    bit prog;
    int lo    [NUM_CH];
    int hi    [NUM_CH];
    int smp_a [NUM_CH];
    int smp_b [NUM_CH];
    bit typed;
    int ang   [NUM_CH];
    int upd   [NUM_CH];
  } win_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  cfg_reg_t          cfg_index;
  logic [SMP_W-1:0]  cfg_wdata;

  fsta_in_if  in_bus  ();
  fsta_out_if out_bus ();

  flex_sensor_to_servo_angle_top #(.SAMPLES(WIN)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [SUM_W-1:0] win_sums   [NUM_CH];
  int               fill_cnt;
  logic [ANG_W-1:0] held_angle [NUM_CH];
  int               bound_lo   [NUM_CH];
  int               bound_hi   [NUM_CH];

  angle_res_t pending_angles [$];

  bit tx_free;
  bit rx_free;
  int err_cnt;
  int items_sent;
  int res_cnt;
  int upd_cnt;
  int bound_sets;
  int cyc_cnt;

  // directed windows; every row is one full window of WIN transactions
  win_row_t dir_tab [DIR_ROWS] = '{
    // reset bounds: zero never inside, full scale maps to 0, midscale to 90
    '{1'b0, '{0, 0, 0, 0}, '{1023, 1023, 1023, 1023},
      '{0, 1023, 1, 512}, '{0, 1023, 1, 512},
      1'b1, '{180, 0, 180, 90}, '{0, 1, 1, 1}},
    // average on low edge held, on high edge maps to 0, above high held
    '{1'b1, '{100, 100, 100, 100}, '{200, 200, 200, 200},
      '{100, 200, 150, 201}, '{100, 200, 150, 201},
      1'b1, '{180, 0, 90, 90}, '{0, 1, 1, 0}},
    // inverted and empty windows never update
    '{1'b1, '{500, 300, 1023, 0}, '{400, 300, 0, 1023},
      '{450, 300, 512, 0}, '{450, 300, 512, 0},
      1'b1, '{180, 0, 90, 90}, '{0, 0, 0, 0}},
    // one-count window at top of range
    '{1'b1, '{1022, 1022, 1022, 1022}, '{1023, 1023, 1023, 1023},
      '{1023, 1023, 1023, 1023}, '{1023, 1023, 1023, 1023},
      1'b1, '{0, 0, 0, 0}, '{1, 1, 1, 1}},
    // one-count window at bottom of range
    '{1'b1, '{0, 0, 0, 0}, '{1, 1, 1, 1},
      '{1, 1, 1, 0}, '{1, 1, 1, 0},
      1'b1, '{0, 0, 0, 0}, '{1, 1, 1, 0}},
    // smallest offset truncates to a full angle
    '{1'b1, '{0, 0, 0, 0}, '{1023, 1023, 1023, 1023},
      '{1, 1, 1, 1}, '{1, 1, 1, 1},
      1'b1, '{180, 180, 180, 180}, '{1, 1, 1, 1}},
    // mixed samples: rounding to tens before the average
    '{1'b1, '{0, 10, 0, 200}, '{1023, 20, 5, 900},
      '{1023, 14, 0, 300}, '{1022, 15, 9, 301},
      1'b0, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
    // alternating extremes, average 511: on the channel 2 high bound, inside the rest
    '{1'b1, '{0, 0, 0, 0}, '{600, 512, 511, 1023},
      '{0, 0, 0, 0}, '{1023, 1023, 1023, 1023},
      1'b0, '{0, 0, 0, 0}, '{0, 0, 0, 0}}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mismatch log
  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("[%0t] %s", $time, msg);
  endtask

  function automatic int clip10(input int v);
    return (v < 0) ? 0 : (v > SMP_MAX) ? SMP_MAX : v;
  endfunction

  // add one sample set to the window; on the closing set, average, map and
  // return the angle transaction the block should emit
  function automatic bit fold_sample_set(input smp_set_t s, output angle_res_t res);
    int avg;
    res = '0;
    for (int ch = 0; ch < NUM_CH; ch++) win_sums[ch] = win_sums[ch] + SUM_W'(s[ch]);
    fill_cnt++;
    if (fill_cnt < WIN) return 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      avg = ((int'(win_sums[ch]) + int'(ROUND_BIAS)) / int'(ROUND_DIV))
            * int'(ROUND_DIV) / WIN;
      // empty or inverted bounds fail this test, so no division happens
      if (bound_lo[ch] < avg && avg <= bound_hi[ch]) begin
        held_angle[ch] = ANG_W'(int'(ANGLE_FULL) - ((avg - bound_lo[ch]) * int'(ANGLE_FULL))
                         / (bound_hi[ch] - bound_lo[ch]));
        res.upd[ch] = 1'b1;
      end
      res.angle[ch] = held_angle[ch];
      win_sums[ch] = '0;
    end
    fill_cnt = 0;
    return 1'b1;
  endfunction

  // send one sample set after a random gap; predict once it is accepted
  task automatic send_set(input smp_set_t s, input bit use_typed, input angle_res_t typed_res);
    int         gap;
    angle_res_t mapped;
    gap = tx_free ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.chan0_sample <= s[0];
    in_bus.chan1_sample <= s[1];
    in_bus.chan2_sample <= s[2];
    in_bus.chan3_sample <= s[3];
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    items_sent++;
    if (fold_sample_set(s, mapped)) pending_angles.push_back(use_typed ? typed_res : mapped);
  endtask

  // write all eight bounds, one per cycle
  task automatic program_bounds(input int lo [NUM_CH], input int hi [NUM_CH]);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      cfg_we    <= 1'b1;
      cfg_index <= LOW_REG[ch];
      cfg_wdata <= SMP_W'(lo[ch]);
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= HIGH_REG[ch];
      cfg_wdata <= SMP_W'(hi[ch]);
      @(posedge clk);
      bound_lo[ch] = lo[ch];
      bound_hi[ch] = hi[ch];
    end
    cfg_we <= 1'b0;
    bound_sets++;
  endtask

  // drop valid, let every expected transaction drain, then cover the latency
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (GUARD_CYCLES) @(posedge clk);
  endtask

  // result side: random stall per transaction, compare against oldest entry
  initial begin : angle_sink
    angle_res_t                   want;
    logic [NUM_CH-1:0][ANG_W-1:0] got_ang;
    logic [NUM_CH-1:0]            got_upd;
    bit                           sink_armed;
    int                           sink_wait;
    sink_armed = 1'b0;
    sink_wait  = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        got_ang = {out_bus.chan3_angle, out_bus.chan2_angle,
                   out_bus.chan1_angle, out_bus.chan0_angle};
        got_upd = {out_bus.chan3_updated, out_bus.chan2_updated,
                   out_bus.chan1_updated, out_bus.chan0_updated};
        res_cnt++;
        if (pending_angles.size() == 0) begin
          report("angle transaction with no closed window pending");
        end else begin
          want = pending_angles.pop_front();
          for (int ch = 0; ch < NUM_CH; ch++) begin
            if (got_ang[ch] !== want.angle[ch])
              report($sformatf("window %0d ch%0d angle: got %0d, expected %0d",
                               res_cnt, ch, got_ang[ch], want.angle[ch]));
            if (got_upd[ch] !== want.upd[ch])
              report($sformatf("window %0d ch%0d updated: got %0b, expected %0b",
                               res_cnt, ch, got_upd[ch], want.upd[ch]));
            if (want.upd[ch]) upd_cnt++;
          end
        end
        sink_armed = 1'b0;
      end else if (rst_n && out_bus.valid === 1'b1 && !sink_armed) begin
        // new transaction on the bus: draw its stall
        sink_armed = 1'b1;
        sink_wait  = rx_free ? 0 : $urandom_range(0, 8);
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      out_bus.ready <= rx_free || (sink_armed && sink_wait == 0);
    end
  end

  // run limit
  initial begin : watchdog
    cyc_cnt = 0;
    while (cyc_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc_cnt++;
    end
    $display("timeout after %0d cycles, %0d windows still pending",
             cyc_cnt, pending_angles.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    smp_set_t   s;
    angle_res_t typed_res;
    int         lo    [NUM_CH];
    int         hi    [NUM_CH];
    int         level [NUM_CH];
    int         jit;
    int         n;
    int         a;
    int         rnd_items;
    bit         noisy;

    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.chan0_sample <= '0;
    in_bus.chan1_sample <= '0;
    in_bus.chan2_sample <= '0;
    in_bus.chan3_sample <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_CH0_LOW;
    cfg_wdata           <= '0;
    tx_free    = 1'b0;
    rx_free    = 1'b0;
    err_cnt    = 0;
    items_sent = 0;
    res_cnt    = 0;
    upd_cnt    = 0;
    bound_sets = 0;
    rnd_items  = 0;
    fill_cnt   = 0;
    jit        = 0;
    noisy      = 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      win_sums[ch]   = '0;
      held_angle[ch] = ANGLE_FULL;
      bound_lo[ch]   = int'(LOW_RST);
      bound_hi[ch]   = int'(HIGH_RST);
      level[ch]      = SMP_MAX / 2;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed windows
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].prog) program_bounds(dir_tab[r].lo, dir_tab[r].hi);
      for (int ch = 0; ch < NUM_CH; ch++) begin
        typed_res.angle[ch] = ANG_W'(dir_tab[r].ang[ch]);
        typed_res.upd[ch]   = dir_tab[r].upd[ch][0];
      end
      for (int k = 0; k < WIN; k++) begin
        for (int ch = 0; ch < NUM_CH; ch++)
          s[ch] = SMP_W'((k % 2 == 0) ? dir_tab[r].smp_a[ch] : dir_tab[r].smp_b[ch]);
        send_set(s, dir_tab[r].typed, typed_res);
      end
      wait_idle();
    end

    // random phases: new bounds, then a run of transactions that rarely
    // lines up with a window, so bound changes fall mid-window too
    while (rnd_items < RANDOM_ITEMS) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        case ($urandom_range(0, 6))
          0: begin lo[ch] = 0; hi[ch] = SMP_MAX; end
          1: begin
            a      = $urandom_range(0, SMP_MAX);
            n      = $urandom_range(0, SMP_MAX);
            lo[ch] = (a < n) ? a : n;
            hi[ch] = (a < n) ? n : a;
          end
          2: begin lo[ch] = $urandom_range(0, SMP_MAX - 1); hi[ch] = lo[ch] + 1; end
          3: begin lo[ch] = $urandom_range(0, SMP_MAX); hi[ch] = lo[ch]; end
          4: begin
            hi[ch] = $urandom_range(0, SMP_MAX - 1);
            lo[ch] = $urandom_range(hi[ch] + 1, SMP_MAX);
          end
          5: begin lo[ch] = 0; hi[ch] = $urandom_range(1, SMP_MAX); end
          default: begin lo[ch] = $urandom_range(0, SMP_MAX - 1); hi[ch] = SMP_MAX; end
        endcase
      end
      program_bounds(lo, hi);
      tx_free = ($urandom_range(0, 3) == 0);
      rx_free = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 150);
      for (int k = 0; k < n; k++) begin
        // a fresh window picks a target level per channel, mostly at or next to the bounds
        if (fill_cnt == 0) begin
          noisy = ($urandom_range(0, 4) == 0);
          jit   = $urandom_range(0, 3);
          for (int ch = 0; ch < NUM_CH; ch++) begin
            case ($urandom_range(0, 5))
              0: level[ch] = bound_lo[ch];
              1: level[ch] = bound_hi[ch];
              2: level[ch] = bound_lo[ch] + 1;
              3: level[ch] = bound_hi[ch] + 1;
              4: level[ch] = (bound_lo[ch] < bound_hi[ch]) ?
                             int'($urandom_range(bound_lo[ch] + 1, bound_hi[ch])) :
                             int'($urandom_range(0, SMP_MAX));
              default: level[ch] = $urandom_range(0, SMP_MAX);
            endcase
          end
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (noisy) begin
            case ($urandom_range(0, 3))
              0:       s[ch] = '0;
              1:       s[ch] = SMP_W'(SMP_MAX);
              default: s[ch] = SMP_W'($urandom_range(0, SMP_MAX));
            endcase
          end else begin
            s[ch] = SMP_W'(clip10(level[ch] + int'($urandom_range(0, 2 * jit)) - jit));
          end
        end
        send_set(s, 1'b0, '0);
        rnd_items++;
      end
      wait_idle();
    end

    $display("%0d sample sets sent, %0d windows closed and compared, %0d bound sets loaded",
             items_sent, res_cnt, bound_sets);
    $display("%0d channel angles remapped inside their bounds, %0d held",
             upd_cnt, NUM_CH * res_cnt - upd_cnt);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
